// ----- rtl/rfid_pkg.sv -----
package rfid_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LOST_W      = $clog2(TABLE_DEPTH + 1);
  localparam int FRAME_LEN   = 21;
  localparam int BIDX_W      = 5;
  localparam int TMR_W       = 21;   // limits are 20 bits; a count never passes limit + 1

  // payload byte positions
  localparam logic [BIDX_W-1:0] POS_ID_HI  = 5'd4;
  localparam logic [BIDX_W-1:0] POS_ID_MID = 5'd5;
  localparam logic [BIDX_W-1:0] POS_ID_LO  = 5'd6;
  localparam logic [BIDX_W-1:0] POS_STR_HI = 5'd9;
  localparam logic [BIDX_W-1:0] POS_STR_LO = 5'd10;
  localparam logic [BIDX_W-1:0] POS_DUR    = 5'd11;
  localparam logic [BIDX_W-1:0] POS_SUM    = 5'd18;
  localparam logic [BIDX_W-1:0] POS_LF     = 5'd19;
  localparam logic [BIDX_W-1:0] POS_LAST   = BIDX_W'(FRAME_LEN - 1);
  localparam logic [7:0]        FRAME_LF   = 8'h0A;
  localparam logic [7:0]        FRAME_CR   = 8'h0D;
  localparam logic [7:0]        ADD_HITS   = 8'd2;
  localparam logic [7:0]        HITS_MAX   = 8'd255;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_REFRESH = 3'd1;
  localparam logic [2:0] EV_ADDED   = 3'd2;
  localparam logic [2:0] EV_REJECT  = 3'd3;
  localparam logic [2:0] EV_CAND    = 3'd4;

  localparam logic [2:0] REG_MAX_PERSIST = 3'd0;
  localparam logic [2:0] REG_TABLE_PER   = 3'd1;
  localparam logic [2:0] REG_BYTE_TO     = 3'd2;
  localparam logic [2:0] REG_CAND_TO     = 3'd3;
  localparam logic [2:0] REG_HDR1        = 3'd4;
  localparam logic [2:0] REG_HDR2        = 3'd5;
  localparam logic [2:0] REG_HDR3        = 3'd6;
  localparam logic [2:0] REG_WEAK        = 3'd7;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [23:0] tag_id;
    logic [2:0]  slot;
    logic [15:0] strength;
    logic [7:0]  duress;
    logic [3:0]  lost_count;
    logic        aged;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  max_persist;
    logic [19:0] table_period;
    logic [19:0] byte_timeout;
    logic [19:0] candidate_timeout;
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [7:0]  header_third;
    logic [15:0] weak_level;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic tick_step;
    logic byte_step;
    logic age_step;
    logic look_step;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic age_go;
    logic frame_hit;
    logic walk_last;
    logic out_free;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TICK, ST_AGE, ST_BYTE, ST_LOOK, ST_COMMIT, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_HDR1, PH_HDR2, PH_HDR3, PH_PAYLOAD
  } phase_t;

endpackage

// ----- rtl/rfid_tag_presence_tracker.sv -----
// RFID tag presence tracker.
// Input channel (in_valid/in_ready/in_data): one transfer is either a byte from
// the reader link (operation 0) or one time tick (operation 1).
// Result channel (out_valid/out_ready/out_data): exactly one result per input
// transfer, in order: frame event, tag fields, table slot, and for ticks the
// aging summary (aged, lost_count).
// Config: APB-style write/read, registers at byte address 4*index, pready tied
// high. Write only while the block is idle.
// Flow: a tick passes the tick step on its way to the result register, and an
// aging pass (one table entry per cycle) when the table period has run out. A
// byte passes the byte step, and when it closes a good frame a table lookup over
// every entry and a commit step. One item is in work at a time; the next is
// accepted once the result has been loaded into the output register.
// Stall: a finished result waits in the output register while the next item is
// already accepted and worked on; it is only held before its own result load
// until out_ready frees the register.
// Reset (rst_n low, synchronous): parser to first-header hunt, timers, table
// and candidate cleared, config back to defaults, output empty.
module rfid_tag_presence_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rfid_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rfid_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rfid_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_PERSIST: cfg_nxt.max_persist       = pwdata[7:0];
        REG_TABLE_PER:   cfg_nxt.table_period      = pwdata[19:0];
        REG_BYTE_TO:     cfg_nxt.byte_timeout      = pwdata[19:0];
        REG_CAND_TO:     cfg_nxt.candidate_timeout = pwdata[19:0];
        REG_HDR1:        cfg_nxt.header_first      = pwdata[7:0];
        REG_HDR2:        cfg_nxt.header_second     = pwdata[7:0];
        REG_HDR3:        cfg_nxt.header_third      = pwdata[7:0];
        REG_WEAK:        cfg_nxt.weak_level        = pwdata[15:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_MAX_PERSIST: prdata = 32'(cfg_r.max_persist);
      REG_TABLE_PER:   prdata = 32'(cfg_r.table_period);
      REG_BYTE_TO:     prdata = 32'(cfg_r.byte_timeout);
      REG_CAND_TO:     prdata = 32'(cfg_r.candidate_timeout);
      REG_HDR1:        prdata = 32'(cfg_r.header_first);
      REG_HDR2:        prdata = 32'(cfg_r.header_second);
      REG_HDR3:        prdata = 32'(cfg_r.header_third);
      REG_WEAK:        prdata = 32'(cfg_r.weak_level);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_persist       <= 8'd30;
      cfg_r.table_period      <= 20'd1000;
      cfg_r.byte_timeout      <= 20'd100;
      cfg_r.candidate_timeout <= 20'd30000;
      cfg_r.header_first      <= 8'd33;
      cfg_r.header_second     <= 8'd42;
      cfg_r.header_third      <= 8'd42;
      cfg_r.weak_level        <= 16'd100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rfid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rfid_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // one item in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  // aging only on ticks, which carry no frame event
  a_aged_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.aged |-> out_data.event_res == EV_NONE)
    else $error("aging result carries a frame event");

  // an added tag has a nonzero id
  a_added_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == EV_ADDED |-> out_data.tag_id != 24'd0)
    else $error("tag added with zero id");

  // a rejected frame reports no tag fields
  a_reject_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == EV_REJECT |->
      out_data.tag_id == 24'd0 && out_data.slot == 3'd0 && out_data.strength == 16'd0)
    else $error("rejected frame with tag fields");
`endif

endmodule

// ----- rtl/rfid_ctrl.sv -----
module rfid_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_ready,
  input  rfid_pkg::sts_t sts,
  output rfid_pkg::cmd_t cmd
);
  import rfid_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = (in_op == OP_TICK) ? ST_TICK : ST_BYTE;
      end
      ST_TICK:   state_nxt = sts.age_go ? ST_AGE : ST_DONE;
      ST_AGE:    if (sts.walk_last) state_nxt = ST_DONE;
      ST_BYTE:   state_nxt = sts.frame_hit ? ST_LOOK : ST_DONE;
      ST_LOOK:   if (sts.walk_last) state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_DONE;
      ST_DONE:   if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_TICK:   cmd.tick_step = 1'b1;
      ST_AGE:    cmd.age_step  = 1'b1;
      ST_BYTE:   cmd.byte_step = 1'b1;
      ST_LOOK:   cmd.look_step = 1'b1;
      ST_COMMIT: cmd.commit    = 1'b1;
      ST_DONE:   cmd.emit      = sts.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- rtl/rfid_dpath.sv -----
module rfid_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  rfid_pkg::cfg_t      cfg,
  input  rfid_pkg::in_item_t  in_data,
  input  rfid_pkg::cmd_t      cmd,
  output rfid_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output rfid_pkg::out_item_t out_data
);
  import rfid_pkg::*;

  // captured item
  logic [7:0] byte_r, byte_nxt;

  // parser
  phase_t            phase_r, phase_nxt;
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        fid_hi_r, fid_hi_nxt, fid_mid_r, fid_mid_nxt, fid_lo_r, fid_lo_nxt;
  logic [7:0]        fstr_hi_r, fstr_hi_nxt, fstr_lo_r, fstr_lo_nxt, fdur_r, fdur_nxt;
  logic [7:0]        fchk_r, fchk_nxt, flf_r, flf_nxt;

  // timers
  logic [TMR_W-1:0] tb_cnt_r, tb_cnt_nxt, by_cnt_r, by_cnt_nxt, cd_cnt_r, cd_cnt_nxt;
  logic             by_fired_r, by_fired_nxt, cd_fired_r, cd_fired_nxt;

  // tag table
  logic [23:0] ent_id_r   [TABLE_DEPTH];
  logic [23:0] ent_id_nxt [TABLE_DEPTH];
  logic [15:0] ent_str_r  [TABLE_DEPTH];
  logic [15:0] ent_str_nxt[TABLE_DEPTH];
  logic [7:0]  ent_dur_r  [TABLE_DEPTH];
  logic [7:0]  ent_dur_nxt[TABLE_DEPTH];
  logic [7:0]  ent_cnt_r  [TABLE_DEPTH];
  logic [7:0]  ent_cnt_nxt[TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ent_pres_r, ent_pres_nxt;

  logic [23:0] cand_id_r, cand_id_nxt;
  logic [7:0]  cand_hits_r, cand_hits_nxt;

  // walk
  logic [IDX_W-1:0] widx_r, widx_nxt, hit_slot_r, hit_slot_nxt, free_slot_r, free_slot_nxt;
  logic             hit_r, hit_nxt, free_r, free_nxt;

  // result
  logic [2:0]        ev_r, ev_nxt;
  logic [23:0]       rid_r, rid_nxt;
  logic [2:0]        rslot_r, rslot_nxt;
  logic [15:0]       rstr_r, rstr_nxt;
  logic [7:0]        rdur_r, rdur_nxt;
  logic [LOST_W-1:0] lost_r, lost_nxt;
  logic              aged_r, aged_nxt;

  out_item_t out_r, out_nxt;
  logic      ov_r, ov_nxt;

  logic [TMR_W-1:0] tb_inc, by_inc, cd_inc;
  logic             tb_fire, by_fire;
  phase_t           eph;
  logic [BIDX_W-1:0] ebidx;
  logic             frame_end, frame_good;
  logic [23:0]      fid;
  logic [7:0]       hits_inc;

  assign tb_inc  = tb_cnt_r + TMR_W'(1);
  assign by_inc  = by_cnt_r + TMR_W'(1);
  assign cd_inc  = cd_cnt_r + TMR_W'(1);
  assign tb_fire = tb_inc > TMR_W'(cfg.table_period);
  assign by_fire = by_fired_r || (by_inc > TMR_W'(cfg.byte_timeout));

  assign eph       = by_fired_r ? PH_HDR1 : phase_r;
  assign ebidx     = by_fired_r ? '0 : bidx_r;
  assign frame_end = (eph == PH_PAYLOAD) && (ebidx == POS_LAST);
  assign fid       = {fid_hi_r, fid_mid_r, fid_lo_r};
  assign frame_good = (sum_r == fchk_r) && (flf_r == FRAME_LF) &&
                      (byte_r == FRAME_CR) && (fid != 24'd0);
  assign hits_inc  = (cand_hits_r != HITS_MAX) ? cand_hits_r + 8'd1 : cand_hits_r;

  assign sts.age_go    = tb_fire;
  assign sts.frame_hit = frame_end && frame_good;
  assign sts.walk_last = (widx_r == IDX_W'(TABLE_DEPTH - 1));
  assign sts.out_free  = !ov_r || out_ready;

  always_comb begin
    byte_nxt = byte_r;
    phase_nxt = phase_r;  bidx_nxt = bidx_r;  sum_nxt = sum_r;
    fid_hi_nxt = fid_hi_r; fid_mid_nxt = fid_mid_r; fid_lo_nxt = fid_lo_r;
    fstr_hi_nxt = fstr_hi_r; fstr_lo_nxt = fstr_lo_r; fdur_nxt = fdur_r;
    fchk_nxt = fchk_r; flf_nxt = flf_r;
    tb_cnt_nxt = tb_cnt_r; by_cnt_nxt = by_cnt_r; cd_cnt_nxt = cd_cnt_r;
    by_fired_nxt = by_fired_r; cd_fired_nxt = cd_fired_r;
    ent_id_nxt = ent_id_r; ent_str_nxt = ent_str_r; ent_dur_nxt = ent_dur_r;
    ent_cnt_nxt = ent_cnt_r; ent_pres_nxt = ent_pres_r;
    cand_id_nxt = cand_id_r; cand_hits_nxt = cand_hits_r;
    widx_nxt = widx_r; hit_slot_nxt = hit_slot_r; free_slot_nxt = free_slot_r;
    hit_nxt = hit_r; free_nxt = free_r;
    ev_nxt = ev_r; rid_nxt = rid_r; rslot_nxt = rslot_r; rstr_nxt = rstr_r;
    rdur_nxt = rdur_r; lost_nxt = lost_r; aged_nxt = aged_r;
    out_nxt = out_r;
    ov_nxt = ov_r && !out_ready;

    if (cmd.load) begin
      byte_nxt = in_data.rx_byte;
      ev_nxt = EV_NONE; rid_nxt = '0; rslot_nxt = '0; rstr_nxt = '0; rdur_nxt = '0;
      lost_nxt = '0; aged_nxt = 1'b0;
      widx_nxt = '0; hit_nxt = 1'b0; free_nxt = 1'b0;
      hit_slot_nxt = '0; free_slot_nxt = '0;
    end

    if (cmd.tick_step) begin
      if (tb_fire) begin
        tb_cnt_nxt = '0;
        aged_nxt = 1'b1;
      end else begin
        tb_cnt_nxt = tb_inc;
      end
      if (!by_fired_r) begin
        by_cnt_nxt = by_inc;
        by_fired_nxt = by_inc > TMR_W'(cfg.byte_timeout);
      end
      if (!cd_fired_r) begin
        cd_cnt_nxt = cd_inc;
        cd_fired_nxt = cd_inc > TMR_W'(cfg.candidate_timeout);
      end
      if (by_fire) begin
        phase_nxt = PH_HDR1;
        bidx_nxt = '0;
      end
    end

    if (cmd.byte_step) begin
      phase_nxt = eph;
      bidx_nxt = ebidx;
      unique case (eph)
        PH_HDR1: if (byte_r == cfg.header_first) begin
          phase_nxt = PH_HDR2; by_cnt_nxt = '0; by_fired_nxt = 1'b0;
        end
        PH_HDR2: if (byte_r == cfg.header_second) begin
          phase_nxt = PH_HDR3; by_cnt_nxt = '0; by_fired_nxt = 1'b0;
        end
        PH_HDR3: if (byte_r == cfg.header_third) begin
          phase_nxt = PH_PAYLOAD; bidx_nxt = '0; by_cnt_nxt = '0; by_fired_nxt = 1'b0;
        end
        PH_PAYLOAD: begin
          by_cnt_nxt = '0;
          by_fired_nxt = 1'b0;
          bidx_nxt = ebidx + BIDX_W'(1);
          if (ebidx == '0)          sum_nxt = byte_r;
          else if (ebidx < POS_SUM) sum_nxt = sum_r + byte_r;
          if (ebidx == POS_ID_HI)  fid_hi_nxt  = byte_r;
          if (ebidx == POS_ID_MID) fid_mid_nxt = byte_r;
          if (ebidx == POS_ID_LO)  fid_lo_nxt  = byte_r;
          if (ebidx == POS_STR_HI) fstr_hi_nxt = byte_r;
          if (ebidx == POS_STR_LO) fstr_lo_nxt = byte_r;
          if (ebidx == POS_DUR)    fdur_nxt    = byte_r;
          if (ebidx == POS_SUM)    fchk_nxt    = byte_r;
          if (ebidx == POS_LF)     flf_nxt     = byte_r;
          if (frame_end) begin
            phase_nxt = PH_HDR1;
            bidx_nxt = '0;
            if (frame_good) begin
              rid_nxt = fid;
              rstr_nxt = {fstr_hi_r, fstr_lo_r};
              rdur_nxt = fdur_r;
            end else begin
              ev_nxt = EV_REJECT;
            end
          end
        end
        default: phase_nxt = PH_HDR1;
      endcase
    end

    if (cmd.age_step) begin
      if (ent_cnt_r[widx_r] > 8'd1) begin
        ent_cnt_nxt[widx_r] = ent_cnt_r[widx_r] - 8'd1;
      end else if ((ent_cnt_r[widx_r] == 8'd1 || ent_str_r[widx_r] < cfg.weak_level)
                   && ent_pres_r[widx_r]) begin
        ent_pres_nxt[widx_r] = 1'b0;
        lost_nxt = lost_r + LOST_W'(1);
      end
    end

    if (cmd.look_step) begin
      if (!hit_r && ent_id_r[widx_r] == rid_r) begin
        hit_nxt = 1'b1; hit_slot_nxt = widx_r;
      end
      if (!free_r && ent_cnt_r[widx_r] == 8'd0) begin
        free_nxt = 1'b1; free_slot_nxt = widx_r;
      end
    end

    if (cmd.age_step || cmd.look_step) widx_nxt = widx_r + IDX_W'(1);

    if (cmd.commit) begin
      ev_nxt = EV_CAND;
      if (hit_r) begin
        ent_cnt_nxt[hit_slot_r] = cfg.max_persist;
        ent_str_nxt[hit_slot_r] = rstr_r;
        ent_dur_nxt[hit_slot_r] = rdur_r;
        ev_nxt = EV_REFRESH;
        rslot_nxt = 3'(hit_slot_r);
      end else if (cand_id_r == 24'd0) begin
        cand_id_nxt = rid_r;
        cand_hits_nxt = '0;
        cd_cnt_nxt = '0;
        cd_fired_nxt = 1'b0;
      end else if (cand_id_r == rid_r) begin
        cand_hits_nxt = hits_inc;
        if (hits_inc > ADD_HITS && free_r) begin
          ent_id_nxt[free_slot_r]  = rid_r;
          ent_str_nxt[free_slot_r] = rstr_r;
          ent_dur_nxt[free_slot_r] = rdur_r;
          ent_pres_nxt[free_slot_r] = 1'b1;
          ent_cnt_nxt[free_slot_r] = cfg.max_persist;
          cand_id_nxt = '0;
          ev_nxt = EV_ADDED;
          rslot_nxt = 3'(free_slot_r);
        end
      end else if (cd_fired_r) begin
        cand_id_nxt = '0;
      end
    end

    if (cmd.emit) begin
      ov_nxt = 1'b1;
      out_nxt.event_res  = ev_r;
      out_nxt.tag_id     = rid_r;
      out_nxt.slot       = rslot_r;
      out_nxt.strength   = rstr_r;
      out_nxt.duress     = rdur_r;
      out_nxt.lost_count = 4'(lost_r);
      out_nxt.aged       = aged_r;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    sum_r <= sum_nxt;
    fid_hi_r <= fid_hi_nxt; fid_mid_r <= fid_mid_nxt; fid_lo_r <= fid_lo_nxt;
    fstr_hi_r <= fstr_hi_nxt; fstr_lo_r <= fstr_lo_nxt; fdur_r <= fdur_nxt;
    fchk_r <= fchk_nxt; flf_r <= flf_nxt;
    widx_r <= widx_nxt; hit_slot_r <= hit_slot_nxt; free_slot_r <= free_slot_nxt;
    hit_r <= hit_nxt; free_r <= free_nxt;
    ev_r <= ev_nxt; rid_r <= rid_nxt; rslot_r <= rslot_nxt; rstr_r <= rstr_nxt;
    rdur_r <= rdur_nxt; lost_r <= lost_nxt; aged_r <= aged_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      phase_r <= PH_HDR1;
      bidx_r <= '0;
      tb_cnt_r <= '0; by_cnt_r <= '0; cd_cnt_r <= '0;
      by_fired_r <= 1'b0; cd_fired_r <= 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        ent_id_r[i] <= '0; ent_str_r[i] <= '0; ent_dur_r[i] <= '0; ent_cnt_r[i] <= '0;
      end
      ent_pres_r <= '0;
      cand_id_r <= '0;
      cand_hits_r <= '0;
      ov_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      bidx_r <= bidx_nxt;
      tb_cnt_r <= tb_cnt_nxt; by_cnt_r <= by_cnt_nxt; cd_cnt_r <= cd_cnt_nxt;
      by_fired_r <= by_fired_nxt; cd_fired_r <= cd_fired_nxt;
      ent_id_r <= ent_id_nxt; ent_str_r <= ent_str_nxt; ent_dur_r <= ent_dur_nxt;
      ent_cnt_r <= ent_cnt_nxt;
      ent_pres_r <= ent_pres_nxt;
      cand_id_r <= cand_id_nxt;
      cand_hits_r <= cand_hits_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule
